// File: rtl/afi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afi_pkg
// Shared constants, types and helpers for the altitude factor interpolator.
// ----------------------------------------------------------------------------
package afi_pkg;

  localparam int unsigned NUM_BREAKPOINTS  = 10;
  localparam int unsigned FACTOR_FRAC_BITS = 14;
  localparam int unsigned MAX_BREAKPOINTS  = 16;
  localparam int unsigned LAST_BP          = NUM_BREAKPOINTS - 1;

  localparam int unsigned ALT_W     = 16;
  localparam int unsigned INV_W     = 20;
  localparam int unsigned CRUISE_W  = 10;
  localparam int unsigned FACTOR_W  = 16;
  localparam int unsigned PENAL_W   = 20;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 64;
  localparam int unsigned CFG_HI_W  = 32;

  // entry width holds the 1.0 ramp start as well as any table entry
  localparam int unsigned E_W      = FACTOR_W + 1;
  localparam int unsigned W_W      = 13;
  localparam int unsigned NUM_W    = E_W + W_W + 1;
  localparam int unsigned NQ_W     = 26;
  localparam int unsigned RECIP_W  = 20;
  localparam int unsigned DIV_W    = 10;
  localparam int unsigned HALF_W   = 12;
  localparam int unsigned SHIFT_W  = 3;

  localparam int unsigned ENT_BITS = MAX_BREAKPOINTS * FACTOR_W;
  localparam int unsigned CFG_ENT_BITS = 2 * CFG_DAT_W + CFG_HI_W;

  localparam int unsigned PENRAW_W = CRUISE_W + INV_W;
  localparam int unsigned PEN_FRAC = 20;
  localparam int unsigned PEN_W    = PEN_FRAC + 4;
  localparam int unsigned PP_W     = FACTOR_W + PEN_W + 1;

  localparam logic [E_W-1:0]      FACTOR_ONE = E_W'(1) << FACTOR_FRAC_BITS;
  localparam logic [FACTOR_W-1:0] FACTOR_MAX = '1;
  localparam logic [PENAL_W-1:0]  PENAL_MAX  = '1;
  localparam logic [PEN_W-1:0]    PEN_ONE    = PEN_W'(1) << PEN_FRAC;
  localparam logic [PEN_W-1:0]    PEN_MAX    = '1;
  localparam logic [PP_W-1:0]     PEN_HALF   = PP_W'(1) << (PEN_FRAC - 1);
  localparam logic [W_W-1:0]      HOLD_SPAN  = W_W'(2000);

  localparam int unsigned RECIP_125 = (1 << NQ_W) / 125;
  localparam int unsigned RECIP_625 = (1 << NQ_W) / 625;

  localparam logic [ALT_W-1:0] BREAK_ALT [MAX_BREAKPOINTS] = '{
    16'd2000,  16'd4000,  16'd6000,  16'd8000,  16'd10000, 16'd12000,
    16'd16000, 16'd20000, 16'd25000, 16'd30000, 16'd35000, 16'd40000,
    16'd45000, 16'd50000, 16'd55000, 16'd60000
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRUST_LO  = 3'd0,
    CFG_THRUST_MID = 3'd1,
    CFG_THRUST_HI  = 3'd2,
    CFG_FUEL_LO    = 3'd3,
    CFG_FUEL_MID   = 3'd4,
    CFG_FUEL_HI    = 3'd5,
    CFG_CRUISE     = 3'd6
  } cfg_reg_t;

  typedef enum logic [1:0] {
    SPAN_2000,
    SPAN_4000,
    SPAN_5000
  } span_code_t;

  typedef struct packed {
    logic s3;
    logic s4;
  } afi_adv_t;

  function automatic span_code_t span_of(input logic [ALT_W-1:0] span);
    span_code_t code;
    case (span)
      16'd2000: code = SPAN_2000;
      16'd4000: code = SPAN_4000;
      default:  code = SPAN_5000;
    endcase
    return code;
  endfunction

  function automatic logic [HALF_W-1:0] span_half(input span_code_t code);
    logic [HALF_W-1:0] h;
    case (code)
      SPAN_2000: h = HALF_W'(1000);
      SPAN_4000: h = HALF_W'(2000);
      default:   h = HALF_W'(2500);
    endcase
    return h;
  endfunction

  function automatic logic [SHIFT_W-1:0] span_shift(input span_code_t code);
    logic [SHIFT_W-1:0] s;
    case (code)
      SPAN_2000: s = SHIFT_W'(4);
      SPAN_4000: s = SHIFT_W'(5);
      default:   s = SHIFT_W'(3);
    endcase
    return s;
  endfunction

  function automatic logic [DIV_W-1:0] span_div(input span_code_t code);
    logic [DIV_W-1:0] d;
    case (code)
      SPAN_2000: d = DIV_W'(125);
      SPAN_4000: d = DIV_W'(125);
      default:   d = DIV_W'(625);
    endcase
    return d;
  endfunction

  function automatic logic [RECIP_W-1:0] span_recip(input span_code_t code);
    logic [RECIP_W-1:0] r;
    case (code)
      SPAN_2000: r = RECIP_W'(RECIP_125);
      SPAN_4000: r = RECIP_W'(RECIP_125);
      default:   r = RECIP_W'(RECIP_625);
    endcase
    return r;
  endfunction

endpackage

// File: rtl/afi_span_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afi_span_div
// Two-stage divide of the blend numerator by its segment span.
// ----------------------------------------------------------------------------
module afi_span_div (
  input  logic                             clk,
  input  afi_pkg::afi_adv_t                adv,
  input  logic [afi_pkg::NUM_W-1:0]        num_s2,
  input  afi_pkg::span_code_t              code_s2,
  output logic [afi_pkg::FACTOR_W-1:0]     q_s4
);
  import afi_pkg::*;

  localparam int unsigned RP_W = NQ_W + RECIP_W;
  localparam int unsigned QM_W = RECIP_W + DIV_W;

  logic [NUM_W-1:0]    shifted;
  logic [NQ_W-1:0]     nq_nxt;
  logic [RP_W-1:0]     rprod;
  logic [RECIP_W-1:0]  q0_nxt;

  logic [NQ_W-1:0]     nq_s3_r;
  logic [RECIP_W-1:0]  q0_s3_r;
  span_code_t          code_s3_r;

  logic [QM_W-1:0]     qm;
  logic [NQ_W-1:0]     rem;
  logic [RECIP_W:0]    q1;
  logic [FACTOR_W-1:0] q_nxt;
  logic [FACTOR_W-1:0] q_s4_r;

  always_comb begin
    shifted = num_s2 >> span_shift(code_s2);
    nq_nxt  = shifted[NQ_W-1:0];
    rprod   = RP_W'(nq_nxt) * RP_W'(span_recip(code_s2));
    q0_nxt  = rprod[RP_W-1:NQ_W];
  end

  always_ff @(posedge clk) begin
    if (adv.s3) begin
      nq_s3_r   <= nq_nxt;
      q0_s3_r   <= q0_nxt;
      code_s3_r <= code_s2;
    end
  end

  // correct the reciprocal estimate, which is low by at most one
  always_comb begin
    qm  = QM_W'(q0_s3_r) * QM_W'(span_div(code_s3_r));
    rem = nq_s3_r - qm[NQ_W-1:0];
    q1  = {1'b0, q0_s3_r} + (RECIP_W + 1)'(rem >= NQ_W'(span_div(code_s3_r)));
    if (q1 > (RECIP_W + 1)'(FACTOR_MAX)) begin
      q_nxt = FACTOR_MAX;
    end else begin
      q_nxt = q1[FACTOR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv.s4) begin
      q_s4_r <= q_nxt;
    end
  end

  assign q_s4 = q_s4_r;

endmodule

// File: rtl/altitude_factor_interpolator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// altitude_factor_interpolator_core
// Five register stages lie between input beat and result beat.
// Throughput: one beat per cycle while out_stall is low; the blend multipliers
// sit in stage 2, the reciprocal divide in stages 3 and 4, the penalty product in 5.
// Reset: synchronous, clears all table registers and cruise speed to zero and
// empties the pipeline. The configuration port is always ready.
// ----------------------------------------------------------------------------
module altitude_factor_interpolator_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [afi_pkg::ALT_W-1:0]         in_altitude,
  input  logic [afi_pkg::INV_W-1:0]         in_inv_airspeed,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [afi_pkg::FACTOR_W-1:0]      out_thrust_factor,
  output logic [afi_pkg::FACTOR_W-1:0]      out_fuel_factor,
  output logic [afi_pkg::PENAL_W-1:0]       out_fuel_factor_penalized,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [afi_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [afi_pkg::CFG_DAT_W-1:0]     cfg_data
);
  import afi_pkg::*;

  // configuration
  logic [CFG_DAT_W-1:0] thr_lo_r, thr_mid_r, fuel_lo_r, fuel_mid_r;
  logic [CFG_HI_W-1:0]  thr_hi_r, fuel_hi_r;
  logic [CRUISE_W-1:0]  cruise_r;

  logic [ENT_BITS-1:0]  thr_flat, fuel_flat;
  logic [FACTOR_W-1:0]  thr_e  [MAX_BREAKPOINTS];
  logic [FACTOR_W-1:0]  fuel_e [MAX_BREAKPOINTS];

  // handshake
  logic adv_out, adv4, adv3, adv2, adv1;
  afi_adv_t div_adv;
  logic v1_r, v2_r, v3_r, v4_r, out_valid_r;

  // stage 1
  logic                found;
  logic [E_W-1:0]      elo_thr_nxt, ehi_thr_nxt, elo_fuel_nxt, ehi_fuel_nxt;
  logic [W_W-1:0]      wlo_nxt, whi_nxt;
  span_code_t          code_nxt;
  logic                below_nxt;
  logic [E_W-1:0]      elo_thr_s1_r, ehi_thr_s1_r, elo_fuel_s1_r, ehi_fuel_s1_r;
  logic [W_W-1:0]      wlo_s1_r, whi_s1_r;
  span_code_t          code_s1_r;
  logic                below_s1_r;
  logic [PENRAW_W-1:0] pen_raw_s1_r;

  // stage 2
  logic [NUM_W-1:0]    num_thr_nxt, num_fuel_nxt;
  logic [PEN_W-1:0]    pen_nxt;
  logic [NUM_W-1:0]    num_thr_s2_r, num_fuel_s2_r;
  span_code_t          code_s2_r;
  logic                below_s2_r;
  logic [PEN_W-1:0]    pen_s2_r;

  // stages 3 and 4
  logic                below_s3_r, below_s4_r;
  logic [PEN_W-1:0]    pen_s3_r, pen_s4_r;
  logic [FACTOR_W-1:0] thr_q, fuel_q;

  // stage 5
  logic [PP_W-1:0]          pen_prod;
  logic [PP_W-PEN_FRAC-1:0] pen_scaled;
  logic [PENAL_W-1:0]       penal_nxt;
  logic [FACTOR_W-1:0]      out_thr_r, out_fuel_r;
  logic [PENAL_W-1:0]       out_penal_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_lo_r   <= '0;
      thr_mid_r  <= '0;
      thr_hi_r   <= '0;
      fuel_lo_r  <= '0;
      fuel_mid_r <= '0;
      fuel_hi_r  <= '0;
      cruise_r   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_THRUST_LO:  thr_lo_r   <= cfg_data;
        CFG_THRUST_MID: thr_mid_r  <= cfg_data;
        CFG_THRUST_HI:  thr_hi_r   <= cfg_data[CFG_HI_W-1:0];
        CFG_FUEL_LO:    fuel_lo_r  <= cfg_data;
        CFG_FUEL_MID:   fuel_mid_r <= cfg_data;
        CFG_FUEL_HI:    fuel_hi_r  <= cfg_data[CFG_HI_W-1:0];
        CFG_CRUISE:     cruise_r   <= cfg_data[CRUISE_W-1:0];
        default: ;
      endcase
    end
  end

  assign thr_flat  = {{(ENT_BITS - CFG_ENT_BITS){1'b0}}, thr_hi_r, thr_mid_r, thr_lo_r};
  assign fuel_flat = {{(ENT_BITS - CFG_ENT_BITS){1'b0}}, fuel_hi_r, fuel_mid_r, fuel_lo_r};

  always_comb begin
    for (int i = 0; i < MAX_BREAKPOINTS; i++) begin
      thr_e[i]  = thr_flat[FACTOR_W*i +: FACTOR_W];
      fuel_e[i] = fuel_flat[FACTOR_W*i +: FACTOR_W];
    end
  end

  // advance chain: a stage moves when empty or when its successor moves
  assign adv_out    = !out_valid_r || !out_stall;
  assign adv4       = !v4_r || adv_out;
  assign adv3       = !v3_r || adv4;
  assign adv2       = !v2_r || adv3;
  assign adv1       = !v1_r || adv2;
  assign in_stall   = !adv1;
  assign div_adv.s3 = adv3;
  assign div_adv.s4 = adv4;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv1)    v1_r        <= in_valid;
      if (adv2)    v2_r        <= v1_r;
      if (adv3)    v3_r        <= v2_r;
      if (adv4)    v4_r        <= v3_r;
      if (adv_out) out_valid_r <= v4_r;
    end
  end

  // stage 1: segment select and raw penalty product
  always_comb begin
    found        = 1'b0;
    below_nxt    = 1'b0;
    elo_thr_nxt  = {1'b0, thr_e[LAST_BP]};
    ehi_thr_nxt  = {1'b0, thr_e[LAST_BP]};
    elo_fuel_nxt = {1'b0, fuel_e[LAST_BP]};
    ehi_fuel_nxt = {1'b0, fuel_e[LAST_BP]};
    wlo_nxt      = HOLD_SPAN;
    whi_nxt      = '0;
    code_nxt     = SPAN_2000;
    if (in_altitude < BREAK_ALT[0]) begin
      below_nxt    = 1'b1;
      elo_thr_nxt  = FACTOR_ONE;
      ehi_thr_nxt  = {1'b0, thr_e[0]};
      elo_fuel_nxt = FACTOR_ONE;
      ehi_fuel_nxt = {1'b0, fuel_e[0]};
      wlo_nxt      = W_W'(BREAK_ALT[0] - in_altitude);
      whi_nxt      = W_W'(in_altitude);
      code_nxt     = span_of(BREAK_ALT[0]);
    end else if (in_altitude < BREAK_ALT[LAST_BP]) begin
      for (int i = 1; i < MAX_BREAKPOINTS; i++) begin
        if (i <= LAST_BP && !found && in_altitude <= BREAK_ALT[i]) begin
          found        = 1'b1;
          elo_thr_nxt  = {1'b0, thr_e[i-1]};
          ehi_thr_nxt  = {1'b0, thr_e[i]};
          elo_fuel_nxt = {1'b0, fuel_e[i-1]};
          ehi_fuel_nxt = {1'b0, fuel_e[i]};
          wlo_nxt      = W_W'(BREAK_ALT[i] - in_altitude);
          whi_nxt      = W_W'(in_altitude - BREAK_ALT[i-1]);
          code_nxt     = span_of(BREAK_ALT[i] - BREAK_ALT[i-1]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      elo_thr_s1_r  <= elo_thr_nxt;
      ehi_thr_s1_r  <= ehi_thr_nxt;
      elo_fuel_s1_r <= elo_fuel_nxt;
      ehi_fuel_s1_r <= ehi_fuel_nxt;
      wlo_s1_r      <= wlo_nxt;
      whi_s1_r      <= whi_nxt;
      code_s1_r     <= code_nxt;
      below_s1_r    <= below_nxt;
      pen_raw_s1_r  <= PENRAW_W'(cruise_r) * PENRAW_W'(in_inv_airspeed);
    end
  end

  // stage 2: weighted sums with rounding offset, penalty clamp
  always_comb begin
    num_thr_nxt  = NUM_W'(elo_thr_s1_r) * NUM_W'(wlo_s1_r)
                 + NUM_W'(ehi_thr_s1_r) * NUM_W'(whi_s1_r)
                 + NUM_W'(span_half(code_s1_r));
    num_fuel_nxt = NUM_W'(elo_fuel_s1_r) * NUM_W'(wlo_s1_r)
                 + NUM_W'(ehi_fuel_s1_r) * NUM_W'(whi_s1_r)
                 + NUM_W'(span_half(code_s1_r));
    if (pen_raw_s1_r < PENRAW_W'(PEN_ONE)) begin
      pen_nxt = PEN_ONE;
    end else if (pen_raw_s1_r > PENRAW_W'(PEN_MAX)) begin
      pen_nxt = PEN_MAX;
    end else begin
      pen_nxt = pen_raw_s1_r[PEN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv2) begin
      num_thr_s2_r  <= num_thr_nxt;
      num_fuel_s2_r <= num_fuel_nxt;
      code_s2_r     <= code_s1_r;
      below_s2_r    <= below_s1_r;
      pen_s2_r      <= pen_nxt;
    end
  end

  // stages 3 and 4: divide by span
  afi_span_div u_div_thr (
    .clk     (clk),
    .adv     (div_adv),
    .num_s2  (num_thr_s2_r),
    .code_s2 (code_s2_r),
    .q_s4    (thr_q)
  );

  afi_span_div u_div_fuel (
    .clk     (clk),
    .adv     (div_adv),
    .num_s2  (num_fuel_s2_r),
    .code_s2 (code_s2_r),
    .q_s4    (fuel_q)
  );

  always_ff @(posedge clk) begin
    if (adv3) begin
      below_s3_r <= below_s2_r;
      pen_s3_r   <= pen_s2_r;
    end
    if (adv4) begin
      below_s4_r <= below_s3_r;
      pen_s4_r   <= pen_s3_r;
    end
  end

  // stage 5: apply penalty
  always_comb begin
    pen_prod   = PP_W'(fuel_q) * PP_W'(pen_s4_r) + PEN_HALF;
    pen_scaled = pen_prod[PP_W-1:PEN_FRAC];
    if (below_s4_r) begin
      penal_nxt = PENAL_W'(fuel_q);
    end else if (pen_scaled > (PP_W - PEN_FRAC)'(PENAL_MAX)) begin
      penal_nxt = PENAL_MAX;
    end else begin
      penal_nxt = pen_scaled[PENAL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv_out) begin
      out_thr_r   <= thr_q;
      out_fuel_r  <= fuel_q;
      out_penal_r <= penal_nxt;
    end
  end

  assign out_valid                 = out_valid_r;
  assign out_thrust_factor         = out_thr_r;
  assign out_fuel_factor           = out_fuel_r;
  assign out_fuel_factor_penalized = out_penal_r;

endmodule

// File: rtl/afi_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afi_checker
// Port-level checks for the altitude factor interpolator.
// ----------------------------------------------------------------------------
module afi_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic [afi_pkg::FACTOR_W-1:0]     out_thrust_factor,
  input logic [afi_pkg::FACTOR_W-1:0]     out_fuel_factor,
  input logic [afi_pkg::PENAL_W-1:0]      out_fuel_factor_penalized
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_thrust_factor) && $stable(out_fuel_factor)
      && $stable(out_fuel_factor_penalized))
    else $error("result beat changed while stalled");

  a_penalty_floor: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_fuel_factor_penalized >= afi_pkg::PENAL_W'(out_fuel_factor))
    else $error("penalized fuel factor below plain fuel factor");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat present after reset");

endmodule

bind altitude_factor_interpolator_core afi_checker u_afi_checker (
  .clk                       (clk),
  .rst_n                     (rst_n),
  .out_valid                 (out_valid),
  .out_stall                 (out_stall),
  .out_thrust_factor         (out_thrust_factor),
  .out_fuel_factor           (out_fuel_factor),
  .out_fuel_factor_penalized (out_fuel_factor_penalized)
);
